### rtl/multi_channel_led_fade_pwm_macros.svh
// Assertion macros shared by the LED fade PWM checker.
`ifndef MULTI_CHANNEL_LED_FADE_PWM_MACROS_SVH
`define MULTI_CHANNEL_LED_FADE_PWM_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MCLFP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("LED fade PWM check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define MCLFP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("LED fade PWM check failed in the next cycle");

`endif

### rtl/mclfp_pkg.sv
// Package with sizes, codes and lane control types of the LED fade PWM block.
`timescale 1ns / 1ps
package mclfp_pkg;
	localparam int CHANNELS = 23;
	localparam int LEVELS = 8;
	localparam int FIELD_BITS = 23;
	localparam int POS_W = (LEVELS > 2) ? $clog2(LEVELS) : 1;
	localparam int DUTY_W = $clog2(LEVELS + 1);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(LEVELS - 1);
	localparam logic [DUTY_W-1:0] DUTY_FULL = DUTY_W'(LEVELS);

	typedef enum logic {
		OP_PWM = 1'b0,
		OP_FADE = 1'b1
	} opcode_t;

	typedef struct packed {
		logic fade;
		logic [POS_W-1:0] pos;
	} lane_ctrl_t;
endpackage

### rtl/mclfp_if.sv
// Handshake interfaces for the tick input and the lit mask output.
`timescale 1ns / 1ps
interface mclfp_in_if;
	import mclfp_pkg::*;
	logic valid;
	logic ready;
	opcode_t opcode;
	logic [FIELD_BITS-1:0] target_mask;
	modport source (output valid, output opcode, output target_mask, input ready);
	modport sink (input valid, input opcode, input target_mask, output ready);
endinterface

interface mclfp_out_if;
	import mclfp_pkg::*;
	logic valid;
	logic ready;
	logic [FIELD_BITS-1:0] lit_mask;
	modport source (output valid, output lit_mask, input ready);
	modport sink (input valid, input lit_mask, output ready);
endinterface

### rtl/mclfp_lane.sv
// One channel lane: duty level register with saturating fade step and PWM compare.
`timescale 1ns / 1ps
module mclfp_lane (
	input logic clk,
	input logic arst_n,
	input mclfp_pkg::lane_ctrl_t ctrl,
	input logic up,
	output logic lit
);
	import mclfp_pkg::*;

	logic [DUTY_W-1:0] duty_q;
	logic [DUTY_W-1:0] duty_next;

	always_comb begin
		duty_next = duty_q;
		if (ctrl.fade) begin
			if (up) begin
				if (duty_q < DUTY_FULL) begin
					duty_next = duty_q + DUTY_W'(1);
				end
			end else if (duty_q != '0) begin
				duty_next = duty_q - DUTY_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			duty_q <= '0;
		end else begin
			duty_q <= duty_next;
		end
	end

	assign lit = (DUTY_W'(ctrl.pos) < duty_next);
endmodule

### rtl/mclfp_merge.sv
// Merge stage: gathers the lane lit bits into the registered output mask.
`timescale 1ns / 1ps
module mclfp_merge (
	input logic clk,
	input logic arst_n,
	input logic load,
	input logic [mclfp_pkg::CHANNELS-1:0] lit,
	mclfp_out_if.source out_item
);
	import mclfp_pkg::*;

	logic [FIELD_BITS-1:0] mask;
	logic valid_q;
	logic [FIELD_BITS-1:0] mask_q;

	for (genvar i = 0; i < FIELD_BITS; i++) begin : g_bit
		if (i < CHANNELS) begin : g_used
			assign mask[i] = lit[i];
		end else begin : g_pad
			assign mask[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_item.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mask_q <= mask;
		end
	end

	assign out_item.valid = valid_q;
	assign out_item.lit_mask = mask_q;
endmodule

### rtl/multi_channel_led_fade_pwm.sv
// Top level of the multi-channel LED dimmer with PWM and soft fade.
// The lit mask of an item is registered and appears on the output in the cycle after its transfer.
// Throughput: one item per clock; a new item is taken while the output register
// holds a result, as long as that result is taken in the same cycle.
// Reset clears the PWM position and all duty levels, so every channel is dark,
// and empties the output register.
`timescale 1ns / 1ps
module multi_channel_led_fade_pwm (
	input logic clk,
	input logic arst_n,
	mclfp_in_if.sink in_item,
	mclfp_out_if.source out_item
);
	import mclfp_pkg::*;

	logic accept;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] pos_next;
	lane_ctrl_t ctrl;
	logic [CHANNELS-1:0] lit;

	assign in_item.ready = !out_item.valid || out_item.ready;
	assign accept = in_item.valid && in_item.ready;

	always_comb begin
		pos_next = pos_q;
		if (accept && in_item.opcode == OP_PWM) begin
			pos_next = (pos_q >= POS_LAST) ? '0 : pos_q + POS_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else begin
			pos_q <= pos_next;
		end
	end

	assign ctrl.fade = accept && in_item.opcode == OP_FADE;
	assign ctrl.pos = pos_next;

	for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
		logic up;
		if (c < FIELD_BITS) begin : g_tgt
			assign up = in_item.target_mask[c];
		end else begin : g_off
			assign up = 1'b0;
		end
		mclfp_lane u_lane (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.up(up),
			.lit(lit[c])
		);
	end

	mclfp_merge u_merge (
		.clk(clk),
		.arst_n(arst_n),
		.load(accept),
		.lit(lit),
		.out_item(out_item)
	);
endmodule

### rtl/mclfp_checker.sv
// Port-level checker for the LED fade PWM block and its bind to the top level.
`timescale 1ns / 1ps
`include "multi_channel_led_fade_pwm_macros.svh"
module mclfp_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic [mclfp_pkg::FIELD_BITS-1:0] lit_mask
);
	import mclfp_pkg::*;

	`MCLFP_ASSERT_NEXT(a_result_follows, clk, arst_n, in_valid && in_ready, out_valid)
	`MCLFP_ASSERT_IMPLY(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)
	`MCLFP_ASSERT_NEXT(a_valid_holds, clk, arst_n, out_valid && !out_ready, out_valid)
	`MCLFP_ASSERT_NEXT(a_mask_holds, clk, arst_n, out_valid && !out_ready, $stable(lit_mask))
endmodule

bind multi_channel_led_fade_pwm mclfp_checker u_mclfp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_item.valid),
	.in_ready(in_item.ready),
	.out_valid(out_item.valid),
	.out_ready(out_item.ready),
	.lit_mask(out_item.lit_mask)
);

### tb/sv/tb_top.sv
// Testbench of the LED fade PWM block: directed and random ticks checked against a predictor and typed masks.
`timescale 1ns / 1ps
module tb_top;
	import mclfp_pkg::*;

	localparam int RANDOM_TICKS = 1930;
	localparam int HOLD_START = 1000;
	localparam int HOLD_CYCLES = 200;
	localparam logic [FIELD_BITS-1:0] ALL_ON = '1;
	localparam logic [FIELD_BITS-1:0] ALL_OFF = '0;

	typedef struct packed {
		opcode_t op;
		logic [FIELD_BITS-1:0] target;
		logic typed;
		logic [FIELD_BITS-1:0] lit;
	} tick_row_t;

	localparam tick_row_t DIRECTED [0:23] = '{
		'{OP_PWM, ALL_ON, 1'b1, ALL_OFF},
		'{OP_FADE, ALL_OFF, 1'b1, ALL_OFF},
		'{OP_FADE, ALL_ON, 1'b0, ALL_OFF},
		'{OP_FADE, ALL_ON, 1'b0, ALL_OFF},
		'{OP_FADE, ALL_ON, 1'b0, ALL_OFF},
		'{OP_FADE, ALL_ON, 1'b0, ALL_OFF},
		'{OP_FADE, ALL_ON, 1'b0, ALL_OFF},
		'{OP_FADE, ALL_ON, 1'b0, ALL_OFF},
		'{OP_FADE, ALL_ON, 1'b0, ALL_OFF},
		'{OP_FADE, ALL_ON, 1'b1, ALL_ON},
		'{OP_FADE, ALL_ON, 1'b1, ALL_ON},
		'{OP_PWM, ALL_OFF, 1'b0, ALL_OFF},
		'{OP_PWM, ALL_OFF, 1'b0, ALL_OFF},
		'{OP_PWM, ALL_OFF, 1'b0, ALL_OFF},
		'{OP_PWM, ALL_OFF, 1'b0, ALL_OFF},
		'{OP_PWM, ALL_OFF, 1'b0, ALL_OFF},
		'{OP_PWM, ALL_OFF, 1'b0, ALL_OFF},
		'{OP_PWM, ALL_OFF, 1'b1, ALL_ON},
		'{OP_FADE, 23'h555555, 1'b0, ALL_OFF},
		'{OP_FADE, 23'h2AAAAA, 1'b0, ALL_OFF},
		'{OP_PWM, 23'h123456, 1'b0, ALL_OFF},
		'{OP_FADE, 23'h000001, 1'b0, ALL_OFF},
		'{OP_FADE, 23'h400000, 1'b0, ALL_OFF},
		'{OP_PWM, ALL_ON, 1'b0, ALL_OFF}
	};

	logic clk;
	logic arst_n;

	mclfp_in_if in_ch ();
	mclfp_out_if out_ch ();

	multi_channel_led_fade_pwm i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_item(in_ch.sink),
		.out_item(out_ch.source)
	);

	logic [POS_W-1:0] pwm_pos;
	logic [DUTY_W-1:0] duty [CHANNELS];
	logic [FIELD_BITS-1:0] expected_lit [$];
	int mismatch_count;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [FIELD_BITS-1:0] step_dimmer(input opcode_t op,
			input logic [FIELD_BITS-1:0] target);
		logic [FIELD_BITS-1:0] lit;
		logic up;
		lit = '0;
		if (op == OP_PWM) begin
			pwm_pos = (pwm_pos >= POS_LAST) ? '0 : pwm_pos + 1'b1;
		end else begin
			for (int c = 0; c < CHANNELS; c++) begin
				up = 1'b0;
				if (c < FIELD_BITS)
					up = target[c];
				if (up) begin
					if (duty[c] < DUTY_FULL)
						duty[c] = duty[c] + 1'b1;
				end else if (duty[c] != '0) begin
					duty[c] = duty[c] - 1'b1;
				end
			end
		end
		for (int c = 0; c < CHANNELS && c < FIELD_BITS; c++)
			lit[c] = ({1'b0, pwm_pos} < duty[c]);
		return lit;
	endfunction

	function automatic logic [FIELD_BITS-1:0] pick_mask();
		case ($urandom_range(3))
			0: return ALL_OFF;
			1: return ALL_ON;
			default: return FIELD_BITS'($urandom());
		endcase
	endfunction

	task automatic send_tick(input opcode_t op, input logic [FIELD_BITS-1:0] target,
			input bit may_idle, input logic typed, input logic [FIELD_BITS-1:0] typed_lit);
		logic [FIELD_BITS-1:0] lit;
		while (may_idle && $urandom_range(99) < 6) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.target_mask <= target;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		lit = step_dimmer(op, target);
		expected_lit.push_back(typed ? typed_lit : lit);
	endtask

	initial begin
		int cycle;
		out_ch.ready <= 1'b0;
		cycle = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle >= HOLD_START && cycle < HOLD_START + HOLD_CYCLES)
				out_ch.ready <= 1'b0;
			else if (cycle >= 1600 && cycle < 1900)
				out_ch.ready <= 1'b1;
			else
				out_ch.ready <= ($urandom_range(99) >= 6);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_lit.size() == 0) begin
				mismatch_count++;
				$display("%0t: lit_mask transfer with nothing expected, actual %h",
					$time, out_ch.lit_mask);
			end else begin
				if (out_ch.lit_mask !== expected_lit[0]) begin
					mismatch_count++;
					$display("%0t: lit_mask expected %h actual %h",
						$time, expected_lit[0], out_ch.lit_mask);
				end
				void'(expected_lit.pop_front());
			end
		end
	end

	initial begin
		logic [FIELD_BITS-1:0] sweep_mask;
		logic [FIELD_BITS-1:0] target;
		opcode_t op;
		mismatch_count = 0;
		pwm_pos = '0;
		for (int c = 0; c < CHANNELS; c++)
			duty[c] = '0;
		sweep_mask = ALL_ON;
		arst_n <= 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.opcode <= OP_PWM;
		in_ch.target_mask <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			send_tick(DIRECTED[i].op, DIRECTED[i].target, 1'b1, DIRECTED[i].typed,
				DIRECTED[i].lit);

		// Fade ticks mostly follow a slowly changing mask so duty levels sweep the full range.
		for (int n = 0; n < RANDOM_TICKS; n++) begin
			if ($urandom_range(15) == 0)
				sweep_mask = pick_mask();
			if ($urandom_range(99) < 50) begin
				op = OP_FADE;
				target = ($urandom_range(3) == 0) ? FIELD_BITS'($urandom()) : sweep_mask;
			end else begin
				op = OP_PWM;
				target = pick_mask();
			end
			send_tick(op, target, !(n >= 1200 && n < 1500), 1'b0, ALL_OFF);
		end
		in_ch.valid <= 1'b0;

		while (expected_lit.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
